### sv/chunked_slot_stack_allocator_macros.svh
// assertion macros used by the checker file
`ifndef CHUNKED_SLOT_STACK_ALLOCATOR_MACROS_SVH
`define CHUNKED_SLOT_STACK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define CSA_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("csa check failed");

// next-cycle implication
`define CSA_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("csa check failed");

`endif

### sv/csa_pkg.sv
package csa_pkg;

  localparam int OP_W   = 2;
  localparam int AMT_W  = 11;
  localparam int IDX_W  = 10;
  localparam int ERR_W  = 3;
  localparam int CNT_W  = 11;
  localparam int SPC_W  = 11;

  localparam logic [SPC_W-1:0] SPC_RESET = 11'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 3'd0,
    ERR_AMOUNT   = 3'd1,
    ERR_CAPACITY = 3'd2,
    ERR_INDEX    = 3'd3,
    ERR_OCCUPIED = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_FREE,
    S_INIT,
    S_DIV,
    S_PLACE,
    S_SCAN,
    S_SCAN_END,
    S_MARK,
    S_FIN,
    S_WALK_RD,
    S_WALK_CK,
    S_DONE
  } state_t;

endpackage

### sv/csa_if.sv
interface csa_in_if;
  logic                       valid;
  logic                       ready;
  logic [csa_pkg::OP_W-1:0]   op;
  logic [csa_pkg::AMT_W-1:0]  amount;
  logic [csa_pkg::IDX_W-1:0]  slot_index;

  modport source (output valid, output op, output amount, output slot_index, input ready);
  modport sink (input valid, input op, input amount, input slot_index, output ready);
endinterface

interface csa_out_if;
  logic                       valid;
  logic                       ready;
  logic [csa_pkg::IDX_W-1:0]  first_slot;
  logic [csa_pkg::ERR_W-1:0]  error_code;
  logic                       misaligned;
  logic [csa_pkg::CNT_W-1:0]  top_slot;
  logic [csa_pkg::CNT_W-1:0]  used_slots;
  logic [csa_pkg::CNT_W-1:0]  chunks_grown;

  modport source (output valid, output first_slot, output error_code, output misaligned,
                  output top_slot, output used_slots, output chunks_grown, input ready);
  modport sink (input valid, input first_slot, input error_code, input misaligned,
                input top_slot, input used_slots, input chunks_grown, output ready);
endinterface

interface csa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [csa_pkg::SPC_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/csa_ram.sv
module csa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/chunked_slot_stack_allocator.sv
// chunked slot stack allocator
// in_ch carries one command item (op, amount, slot_index); out_ch returns one
// result item per command; the user writes slots_per_chunk on cfg_ch only while
// the block is idle; the block does not enforce it. one command at a time:
// in_ch.ready is high only while the sequencer is idle.
// steps per op:
//   alloc runs two passes of the shared bit-serial divider, one read pass and
//   one write pass over the run through the bitmap ram ports
//   free clears a valid slot and, if it lies just below top, walks top down over
//   clear slots
//   init clears the bitmap, one entry per cycle
// the bitmap ram has one write port and one registered read port.
// after reset the bitmap is swept clear with in_ch.ready low; cfg writes are
// taken during that time.
// the result sits in an output register: a stalled receiver holds it there, the
// next command is still accepted and waits in its done step until the register
// frees up.
module chunked_slot_stack_allocator #(
  parameter int CAPACITY = 1024
) (
  input logic     clk,
  input logic     rst_n,
  csa_in_if.sink  in_ch,
  csa_out_if.source out_ch,
  csa_cfg_if.sink cfg_ch
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int TW  = $clog2(CAPACITY + 1);
  localparam int CW  = $clog2(TW + 1);
  localparam int EW  = ((TW > 12) ? TW : 12) + 1;
  localparam int MAW = (TW > csa_pkg::AMT_W) ? TW : csa_pkg::AMT_W;
  localparam int PW  = MAW + csa_pkg::SPC_W;
  localparam int SW  = ((TW > csa_pkg::AMT_W) ? TW : csa_pkg::AMT_W) + 1;
  localparam int DSW = csa_pkg::SPC_W + 1;

  localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [TW-1:0] CAP_T = TW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] DIV_STEPS = CW'(TW);

  csa_pkg::state_t state_r, state_nxt;

  csa_pkg::op_t              op_r, op_nxt;
  logic [csa_pkg::AMT_W-1:0] amount_r, amount_nxt;
  logic [csa_pkg::IDX_W-1:0] sidx_r, sidx_nxt;
  logic [csa_pkg::SPC_W-1:0] spc_r, spc_nxt;
  logic [TW-1:0]             top_r, top_nxt;
  logic [TW-1:0]             used_r, used_nxt;
  logic [TW-1:0]             chunks_r, chunks_nxt;
  csa_pkg::err_t             err_r, err_nxt;
  logic [AW-1:0]             first_r, first_nxt;
  logic                      mis_r, mis_nxt;
  logic [AW-1:0]             start_r, start_nxt;
  logic [TW-1:0]             chunk1_r, chunk1_nxt;
  logic                      hit_r, hit_nxt;
  logic                      chk_vld_r, chk_vld_nxt;
  logic [csa_pkg::AMT_W-1:0] idx_r, idx_nxt;
  logic [AW-1:0]             clr_addr_r, clr_addr_nxt;
  logic                      clr_init_r, clr_init_nxt;
  logic [TW-1:0]             q_r, q_nxt;
  logic [csa_pkg::SPC_W-1:0] rem_r, rem_nxt;
  logic [csa_pkg::SPC_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]             div_cnt_r, div_cnt_nxt;
  logic                      div_sel_r, div_sel_nxt;
  logic [PW-1:0]             prod_r, prod_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [csa_pkg::IDX_W-1:0] out_first_r, out_first_nxt;
  logic [csa_pkg::ERR_W-1:0] out_err_r, out_err_nxt;
  logic                      out_mis_r, out_mis_nxt;
  logic [csa_pkg::CNT_W-1:0] out_top_r, out_top_nxt;
  logic [csa_pkg::CNT_W-1:0] out_used_r, out_used_nxt;
  logic [csa_pkg::CNT_W-1:0] out_chunks_r, out_chunks_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic                      ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic                      ram_rdata;

  logic                      in_fire;
  csa_pkg::op_t              op_in;
  logic [csa_pkg::SPC_W-1:0] spc_eff;
  logic                      amt_in_bad;
  logic                      init_in_bad;
  logic [DSW-1:0]            div_sh;
  logic                      div_ge;
  logic [DSW-1:0]            div_sub;
  logic                      div_last;
  logic [TW-1:0]             base;
  logic                      wrap;
  logic [EW-1:0]             start_e;
  logic [EW-1:0]             end_e;
  logic                      place_over;
  logic [31:0]               chunk1_w;
  logic [31:0]               scan_addr_w;
  logic                      run_last;
  logic                      hit_now;
  logic [PW-1:0]             cov;
  logic                      free_bad;
  logic [TW-1:0]             tm1;
  logic                      free_walk;
  logic                      walk_more;
  logic                      init_over;
  logic                      clr_last;
  logic                      out_free;
  logic [SW-1:0]             used_sum;
  logic [31:0]               sidx_w;
  logic [31:0]               amt_w;
  logic [31:0]               first_w;
  logic [31:0]               top_w;
  logic [31:0]               used_w;
  logic [31:0]               chunks_w;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign op_in       = csa_pkg::op_t'(in_ch.op);
  assign spc_eff     = (spc_r == '0) ? csa_pkg::SPC_W'(1) : spc_r;
  assign amt_in_bad  = (in_ch.amount == '0) || (in_ch.amount > spc_eff);
  assign init_in_bad = (in_ch.amount == '0);

  assign div_sh   = {rem_r, q_r[TW-1]};
  assign div_ge   = div_sh >= {1'b0, dvs_r};
  assign div_sub  = div_sh - {1'b0, dvs_r};
  assign div_last = (div_cnt_r == CW'(1));

  assign base       = top_r - TW'(rem_r);
  assign wrap       = (DSW'(rem_r) + DSW'(amount_r)) > DSW'(spc_eff);
  assign start_e    = wrap ? (EW'(base) + EW'(spc_eff)) : EW'(top_r);
  assign end_e      = wrap ? (EW'(base) + EW'(spc_eff) + EW'(spc_eff))
                           : (EW'(base) + EW'(spc_eff));
  assign place_over = end_e > CAP_E;
  assign chunk1_w   = wrap ? (32'(q_r) + 32'd2) : (32'(q_r) + 32'd1);

  assign scan_addr_w = 32'(start_r) + 32'(idx_r);
  assign run_last    = (DSW'(idx_r) + DSW'(1)) == DSW'(amount_r);
  assign hit_now     = hit_r || (chk_vld_r && ram_rdata);

  assign cov       = (prod_r > CAP_P) ? CAP_P : prod_r;
  assign free_bad  = PW'(sidx_r) >= cov;
  assign tm1       = top_r - TW'(1);
  assign sidx_w    = 32'(sidx_r);
  assign free_walk = (top_r != '0) && (sidx_w == 32'(tm1));
  assign walk_more = (tm1 != '0);
  assign init_over = prod_r > CAP_P;
  assign clr_last  = (clr_addr_r == LAST_A);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign used_sum  = SW'(used_r) + SW'(amount_r);
  assign amt_w     = 32'(amount_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csa_pkg::S_CLR: begin
        if (clr_last) begin
          state_nxt = clr_init_r ? csa_pkg::S_DONE : csa_pkg::S_IDLE;
        end
      end
      csa_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (op_in)
            csa_pkg::OP_ALLOC: state_nxt = amt_in_bad ? csa_pkg::S_DONE : csa_pkg::S_DIV;
            csa_pkg::OP_FREE:  state_nxt = csa_pkg::S_MUL;
            csa_pkg::OP_INIT:  state_nxt = init_in_bad ? csa_pkg::S_DONE : csa_pkg::S_MUL;
            default:           state_nxt = csa_pkg::S_DONE;
          endcase
        end
      end
      csa_pkg::S_MUL: begin
        state_nxt = (op_r == csa_pkg::OP_FREE) ? csa_pkg::S_FREE : csa_pkg::S_INIT;
      end
      csa_pkg::S_FREE: begin
        state_nxt = (!free_bad && free_walk) ? csa_pkg::S_WALK_RD : csa_pkg::S_DONE;
      end
      csa_pkg::S_INIT: begin
        state_nxt = init_over ? csa_pkg::S_DONE : csa_pkg::S_CLR;
      end
      csa_pkg::S_DIV: begin
        if (div_last) begin
          state_nxt = div_sel_r ? csa_pkg::S_FIN : csa_pkg::S_PLACE;
        end
      end
      csa_pkg::S_PLACE: begin
        state_nxt = place_over ? csa_pkg::S_DONE : csa_pkg::S_SCAN;
      end
      csa_pkg::S_SCAN: begin
        if (run_last) begin
          state_nxt = csa_pkg::S_SCAN_END;
        end
      end
      csa_pkg::S_SCAN_END: begin
        state_nxt = hit_now ? csa_pkg::S_DONE : csa_pkg::S_MARK;
      end
      csa_pkg::S_MARK: begin
        if (run_last) begin
          state_nxt = csa_pkg::S_DIV;
        end
      end
      csa_pkg::S_FIN:     state_nxt = csa_pkg::S_DONE;
      csa_pkg::S_WALK_RD: state_nxt = csa_pkg::S_WALK_CK;
      csa_pkg::S_WALK_CK: begin
        state_nxt = (!ram_rdata && walk_more) ? csa_pkg::S_WALK_RD : csa_pkg::S_DONE;
      end
      csa_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = csa_pkg::S_IDLE;
        end
      end
      default: state_nxt = csa_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt       = op_r;
    amount_nxt   = amount_r;
    sidx_nxt     = sidx_r;
    top_nxt      = top_r;
    used_nxt     = used_r;
    chunks_nxt   = chunks_r;
    err_nxt      = err_r;
    first_nxt    = first_r;
    mis_nxt      = mis_r;
    start_nxt    = start_r;
    chunk1_nxt   = chunk1_r;
    hit_nxt      = hit_r;
    chk_vld_nxt  = (state_r == csa_pkg::S_SCAN);
    idx_nxt      = idx_r;
    clr_addr_nxt = clr_addr_r;
    clr_init_nxt = clr_init_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    dvs_nxt      = dvs_r;
    div_cnt_nxt  = div_cnt_r;
    div_sel_nxt  = div_sel_r;
    prod_nxt     = prod_r;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_r;
    ram_wdata    = 1'b0;
    ram_raddr    = scan_addr_w[AW-1:0];

    unique case (state_r)
      csa_pkg::S_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      csa_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt     = op_in;
          amount_nxt = in_ch.amount;
          sidx_nxt   = in_ch.slot_index;
          err_nxt    = csa_pkg::ERR_OK;
          first_nxt  = '0;
          mis_nxt    = 1'b0;
          if (op_in == csa_pkg::OP_ALLOC) begin
            if (amt_in_bad) begin
              err_nxt = csa_pkg::ERR_AMOUNT;
            end else begin
              q_nxt       = top_r;
              rem_nxt     = '0;
              dvs_nxt     = spc_eff;
              div_cnt_nxt = DIV_STEPS;
              div_sel_nxt = 1'b0;
            end
          end else if (op_in == csa_pkg::OP_INIT && init_in_bad) begin
            err_nxt = csa_pkg::ERR_AMOUNT;
          end
        end
      end
      csa_pkg::S_MUL: begin
        if (op_r == csa_pkg::OP_FREE) begin
          prod_nxt = PW'(MAW'(chunks_r)) * PW'(spc_eff);
        end else begin
          prod_nxt = PW'(MAW'(amount_r)) * PW'(spc_eff);
        end
      end
      csa_pkg::S_FREE: begin
        if (free_bad) begin
          err_nxt = csa_pkg::ERR_INDEX;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = sidx_w[AW-1:0];
          ram_wdata = 1'b0;
          used_nxt  = (used_r != '0) ? (used_r - TW'(1)) : used_r;
        end
      end
      csa_pkg::S_INIT: begin
        if (init_over) begin
          err_nxt = csa_pkg::ERR_CAPACITY;
        end else begin
          if (MAW'(amount_r) > MAW'(chunks_r)) begin
            chunks_nxt = amt_w[TW-1:0];
          end
          clr_addr_nxt = '0;
          clr_init_nxt = 1'b1;
        end
      end
      csa_pkg::S_DIV: begin
        if (div_ge) begin
          rem_nxt = div_sub[csa_pkg::SPC_W-1:0];
          q_nxt   = {q_r[TW-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[csa_pkg::SPC_W-1:0];
          q_nxt   = {q_r[TW-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - CW'(1);
      end
      csa_pkg::S_PLACE: begin
        if (place_over) begin
          err_nxt = csa_pkg::ERR_CAPACITY;
        end else begin
          start_nxt  = start_e[AW-1:0];
          chunk1_nxt = chunk1_w[TW-1:0];
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
        end
      end
      csa_pkg::S_SCAN: begin
        ram_raddr = scan_addr_w[AW-1:0];
        idx_nxt   = idx_r + csa_pkg::AMT_W'(1);
        hit_nxt   = hit_now;
      end
      csa_pkg::S_SCAN_END: begin
        hit_nxt = hit_now;
        idx_nxt = '0;
        if (hit_now) begin
          err_nxt = csa_pkg::ERR_OCCUPIED;
        end
      end
      csa_pkg::S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = scan_addr_w[AW-1:0];
        ram_wdata = 1'b1;
        idx_nxt   = idx_r + csa_pkg::AMT_W'(1);
        if (run_last) begin
          q_nxt       = TW'(start_r);
          rem_nxt     = '0;
          dvs_nxt     = amount_r;
          div_cnt_nxt = DIV_STEPS;
          div_sel_nxt = 1'b1;
        end
      end
      csa_pkg::S_FIN: begin
        mis_nxt   = (rem_r != '0);
        first_nxt = start_r;
        top_nxt   = TW'(start_r) + TW'(amount_r);
        used_nxt  = (used_sum > CAP_S) ? CAP_T : used_sum[TW-1:0];
        if (chunk1_r > chunks_r) begin
          chunks_nxt = chunk1_r;
        end
      end
      csa_pkg::S_WALK_RD: begin
        ram_raddr = tm1[AW-1:0];
      end
      csa_pkg::S_WALK_CK: begin
        if (!ram_rdata) begin
          top_nxt = tm1;
        end
      end
      csa_pkg::S_DONE: begin
        clr_init_nxt = 1'b0;
      end
      default: begin
        clr_init_nxt = 1'b0;
      end
    endcase
  end

  // result register
  assign first_w  = 32'(first_r);
  assign top_w    = 32'(top_r);
  assign used_w   = 32'(used_r);
  assign chunks_w = 32'(chunks_r);

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_first_nxt  = out_first_r;
    out_err_nxt    = out_err_r;
    out_mis_nxt    = out_mis_r;
    out_top_nxt    = out_top_r;
    out_used_nxt   = out_used_r;
    out_chunks_nxt = out_chunks_r;
    if (state_r == csa_pkg::S_DONE && out_free) begin
      out_valid_nxt  = 1'b1;
      out_first_nxt  = first_w[csa_pkg::IDX_W-1:0];
      out_err_nxt    = err_r;
      out_mis_nxt    = mis_r;
      out_top_nxt    = top_w[csa_pkg::CNT_W-1:0];
      out_used_nxt   = used_w[csa_pkg::CNT_W-1:0];
      out_chunks_nxt = chunks_w[csa_pkg::CNT_W-1:0];
    end
  end

  assign spc_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : spc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csa_pkg::S_CLR;
      clr_addr_r  <= '0;
      clr_init_r  <= 1'b0;
      top_r       <= '0;
      used_r      <= '0;
      chunks_r    <= '0;
      spc_r       <= csa_pkg::SPC_RESET;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      div_cnt_r   <= '0;
      div_sel_r   <= 1'b0;
      idx_r       <= '0;
      op_r        <= csa_pkg::OP_NOP;
      err_r       <= csa_pkg::ERR_OK;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_init_r  <= clr_init_nxt;
      top_r       <= top_nxt;
      used_r      <= used_nxt;
      chunks_r    <= chunks_nxt;
      spc_r       <= spc_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      hit_r       <= hit_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_sel_r   <= div_sel_nxt;
      idx_r       <= idx_nxt;
      op_r        <= op_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amount_r     <= amount_nxt;
    sidx_r       <= sidx_nxt;
    first_r      <= first_nxt;
    mis_r        <= mis_nxt;
    start_r      <= start_nxt;
    chunk1_r     <= chunk1_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    dvs_r        <= dvs_nxt;
    prod_r       <= prod_nxt;
    out_first_r  <= out_first_nxt;
    out_err_r    <= out_err_nxt;
    out_mis_r    <= out_mis_nxt;
    out_top_r    <= out_top_nxt;
    out_used_r   <= out_used_nxt;
    out_chunks_r <= out_chunks_nxt;
  end

  csa_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready         = (state_r == csa_pkg::S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.first_slot   = out_first_r;
  assign out_ch.error_code   = out_err_r;
  assign out_ch.misaligned   = out_mis_r;
  assign out_ch.top_slot     = out_top_r;
  assign out_ch.used_slots   = out_used_r;
  assign out_ch.chunks_grown = out_chunks_r;

endmodule

### sv/csa_checker.sv
`include "chunked_slot_stack_allocator_macros.svh"

module csa_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [csa_pkg::IDX_W-1:0] out_first_slot,
  input logic [csa_pkg::ERR_W-1:0] out_error_code,
  input logic                      out_misaligned,
  input logic [csa_pkg::CNT_W-1:0] out_top_slot
);

  logic err_out;
  logic out_wait;

  assign err_out  = out_valid && (out_error_code != csa_pkg::ERR_OK);
  assign out_wait = out_valid && !out_ready;

  // one command in flight at a time
  `CSA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // failed commands report no run
  `CSA_ASSERT_NOW(a_err_no_run, clk, rst_n, err_out, (out_first_slot == '0) && !out_misaligned)

  `CSA_ASSERT_NOW(a_err_code_range, clk, rst_n, out_valid, out_error_code <= csa_pkg::ERR_OCCUPIED)

  `CSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_error_code))

  `CSA_ASSERT_NEXT(a_top_hold, clk, rst_n, out_wait, $stable(out_top_slot))

endmodule

bind chunked_slot_stack_allocator csa_checker u_csa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_first_slot (out_ch.first_slot),
  .out_error_code (out_ch.error_code),
  .out_misaligned (out_ch.misaligned),
  .out_top_slot   (out_ch.top_slot)
);
